// ----- sv/vfd_pkg.sv -----
package vfd_pkg;

   // Frame format
   localparam int MAX_VARINT_BYTES = 5;
   localparam logic [7:0] INDICATOR_BYTE = 8'h00;

   // Message types acted on at frame end
   localparam logic [31:0] TYPE_DISCONNECT_REQ = 32'd5;
   localparam logic [31:0] TYPE_DISCONNECT_RSP = 32'd6;
   localparam logic [31:0] TYPE_PING_RESPONSE  = 32'd8;

   // Word kinds on the request channel
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Result events
   localparam logic [2:0] EV_NONE       = 3'd0;
   localparam logic [2:0] EV_HEADER     = 3'd1;
   localparam logic [2:0] EV_PAYLOAD    = 3'd2;
   localparam logic [2:0] EV_PING       = 3'd3;
   localparam logic [2:0] EV_CLOSED_ERR = 3'd4;
   localparam logic [2:0] EV_CLOSED_REQ = 3'd5;

   // Fatal error codes
   localparam logic [2:0] ERR_NONE         = 3'd0;
   localparam logic [2:0] ERR_BAD_IND      = 3'd1;
   localparam logic [2:0] ERR_BAD_SIZE     = 3'd2;
   localparam logic [2:0] ERR_BAD_TYPE     = 3'd3;
   localparam logic [2:0] ERR_TOO_LARGE    = 3'd4;
   localparam logic [2:0] ERR_PING_TIMEOUT = 3'd5;

   // Register map
   localparam logic [1:0] CSR_MAX_PAYLOAD = 2'd0;
   localparam logic [1:0] CSR_KEEPALIVE   = 2'd1;
   localparam logic [1:0] CSR_DISCONNECT  = 2'd2;

   localparam logic [15:0] RST_MAX_PAYLOAD = 16'd512;
   localparam logic [31:0] RST_KEEPALIVE   = 32'd60000;
   localparam logic [31:0] RST_DISCONNECT  = 32'd150000;

   typedef enum logic [1:0] {
      PH_IND,
      PH_SIZE,
      PH_TYPE,
      PH_PAY
   } phase_type;

   typedef struct packed {
      logic [15:0] max_payload_bytes;
      logic [31:0] keepalive_ticks;
      logic [31:0] disconnect_ticks;
   } cfg_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [31:0] msg_code;
      logic [15:0] payload_length;
      logic [7:0]  payload_value;
      logic        frame_last;
      logic [2:0]  error_code;
   } rsp_item_type;

endpackage

// ----- sv/vfd_channels.sv -----
interface vfd_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] data_byte;

   modport source (output valid, operation, data_byte, input ready);
   modport sink (input valid, operation, data_byte, output ready);
endinterface

interface vfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [31:0] msg_code;
   logic [15:0] payload_length;
   logic [7:0]  payload_value;
   logic        frame_last;
   logic [2:0]  error_code;

   modport source (output valid, event_res, msg_code, payload_length, payload_value,
                   frame_last, error_code, input ready);
   modport sink (input valid, event_res, msg_code, payload_length, payload_value,
                 frame_last, error_code, output ready);
endinterface

// ----- sv/vfd_csr.sv -----
module vfd_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_write_data,
   output vfd_pkg::cfg_type cfg
);
   import vfd_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // register writes; unknown index is dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_PAYLOAD: cfg_in.max_payload_bytes = csr_write_data[15:0];
            CSR_KEEPALIVE:   cfg_in.keepalive_ticks   = csr_write_data;
            CSR_DISCONNECT:  cfg_in.disconnect_ticks  = csr_write_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_payload_bytes <= RST_MAX_PAYLOAD;
         cfg_ff.keepalive_ticks   <= RST_KEEPALIVE;
         cfg_ff.disconnect_ticks  <= RST_DISCONNECT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/vfd_in_stage.sv -----
module vfd_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   vfd_req_if.sink               req_if,
   input  logic                  drain,
   output logic                  item_fire,
   output vfd_pkg::req_item_type item
);
   import vfd_pkg::*;

   logic         s1_valid_ff, s1_valid_in;
   req_item_type item_ff;
   logic         take;

   // take a word when the stage is empty or the held one moves on this cycle
   assign req_if.ready = !s1_valid_ff || drain;
   assign take         = req_if.valid && req_if.ready;
   assign item_fire    = s1_valid_ff && drain;
   assign item         = item_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take)
         s1_valid_in = 1'b1;
      else if (drain)
         s1_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else
         s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.operation <= req_if.operation;
         item_ff.data_byte <= req_if.data_byte;
      end
   end

endmodule

// ----- sv/vfd_core.sv -----
module vfd_core (
   input  logic                  clock,
   input  logic                  reset,
   input  vfd_pkg::cfg_type      cfg,
   input  logic                  item_fire,
   input  vfd_pkg::req_item_type item,
   output vfd_pkg::rsp_item_type result
);
   import vfd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [15:0] size_ff, size_in;
   logic [31:0] type_ff, type_in;
   logic [15:0] remain_ff, remain_in;
   logic [31:0] idle_ff, idle_in;
   logic        ping_ff, ping_in;
   logic        closed_ff, closed_in;
   logic        over_ff, over_in;

   logic [31:0] grp_shifted;
   logic [31:0] acc_or;
   logic [2:0]  cnt_inc;
   logic        cont;
   logic        too_long;
   logic [31:0] idle_inc;
   logic        over_ka;
   logic        over_dc;
   logic [15:0] remain_dec;
   logic [31:0] end_type;
   logic        ping_clear;
   logic        close_req;
   logic        frame_end;
   logic        is_byte;

   // varint group placed at its 7-bit slot, truncated to 32 bits
   always_comb begin
      case (cnt_ff)
         3'd0:    grp_shifted = {25'd0, item.data_byte[6:0]};
         3'd1:    grp_shifted = {18'd0, item.data_byte[6:0], 7'd0};
         3'd2:    grp_shifted = {11'd0, item.data_byte[6:0], 14'd0};
         3'd3:    grp_shifted = {4'd0, item.data_byte[6:0], 21'd0};
         3'd4:    grp_shifted = {item.data_byte[3:0], 28'd0};
         default: grp_shifted = 32'd0;
      endcase
   end

   assign acc_or   = acc_ff | grp_shifted;
   assign cnt_inc  = cnt_ff + 3'd1;
   assign cont     = item.data_byte[7];
   assign too_long = cnt_inc >= 3'(MAX_VARINT_BYTES);
   assign is_byte  = item.operation == OP_BYTE;

   // keepalive: saturating idle count and the two limits
   assign idle_inc = (idle_ff == '1) ? idle_ff : idle_ff + 32'd1;
   assign over_ka  = idle_inc > cfg.keepalive_ticks;
   assign over_dc  = idle_inc > cfg.disconnect_ticks;

   assign remain_dec = remain_ff - 16'd1;

   // frame end: zero-size header or last payload byte
   assign end_type   = (phase_ff == PH_TYPE) ? acc_or : type_ff;
   assign ping_clear = end_type == TYPE_PING_RESPONSE;
   assign close_req  = (end_type == TYPE_DISCONNECT_REQ) || (end_type == TYPE_DISCONNECT_RSP);
   assign frame_end  = !closed_ff && is_byte &&
                       (((phase_ff == PH_TYPE) && !cont && !over_ff && (size_ff == 16'd0)) ||
                        ((phase_ff == PH_PAY) && (remain_dec == 16'd0)));

   // next state
   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      size_in   = size_ff;
      type_in   = type_ff;
      remain_in = remain_ff;
      idle_in   = idle_ff;
      ping_in   = ping_ff;
      closed_in = closed_ff;
      over_in   = over_ff;
      if (item_fire && !closed_ff) begin
         if (!is_byte) begin
            idle_in = idle_inc;
            if (over_ka) begin
               if (!ping_ff) begin
                  ping_in = 1'b1;
               end else if (over_dc) begin
                  closed_in = 1'b1;
                  phase_in  = PH_IND;
               end
            end
         end else begin
            case (phase_ff)
               PH_SIZE, PH_TYPE: begin
                  acc_in = acc_or;
                  cnt_in = cnt_inc;
                  if (cont) begin
                     if (too_long) begin
                        closed_in = 1'b1;
                        phase_in  = PH_IND;
                     end
                  end else if (phase_ff == PH_SIZE) begin
                     over_in  = acc_or > {16'd0, cfg.max_payload_bytes};
                     size_in  = acc_or[15:0];
                     acc_in   = '0;
                     cnt_in   = '0;
                     phase_in = PH_TYPE;
                  end else begin
                     type_in = acc_or;
                     acc_in  = '0;
                     cnt_in  = '0;
                     if (over_ff) begin
                        closed_in = 1'b1;
                        phase_in  = PH_IND;
                     end else begin
                        remain_in = size_ff;
                        if (size_ff != 16'd0)
                           phase_in = PH_PAY;
                     end
                  end
               end
               PH_PAY: begin
                  remain_in = remain_dec;
               end
               default: begin
                  if (item.data_byte != INDICATOR_BYTE) begin
                     closed_in = 1'b1;
                     phase_in  = PH_IND;
                  end else begin
                     phase_in = PH_SIZE;
                     acc_in   = '0;
                     cnt_in   = '0;
                     over_in  = 1'b0;
                  end
               end
            endcase
            if (frame_end) begin
               idle_in  = '0;
               phase_in = PH_IND;
               if (ping_clear)
                  ping_in = 1'b0;
               if (close_req)
                  closed_in = 1'b1;
            end
         end
      end
   end

   // result word
   always_comb begin
      result = '0;
      if (!closed_ff) begin
         if (!is_byte) begin
            if (over_ka) begin
               if (!ping_ff) begin
                  result.event_res = EV_PING;
               end else if (over_dc) begin
                  result.event_res  = EV_CLOSED_ERR;
                  result.error_code = ERR_PING_TIMEOUT;
               end
            end
         end else begin
            case (phase_ff)
               PH_SIZE, PH_TYPE: begin
                  if (cont) begin
                     if (too_long) begin
                        result.event_res  = EV_CLOSED_ERR;
                        result.error_code = (phase_ff == PH_SIZE) ? ERR_BAD_SIZE : ERR_BAD_TYPE;
                     end
                  end else if (phase_ff == PH_TYPE) begin
                     if (over_ff) begin
                        result.event_res  = EV_CLOSED_ERR;
                        result.error_code = ERR_TOO_LARGE;
                     end else begin
                        result.event_res      = EV_HEADER;
                        result.msg_code       = acc_or;
                        result.payload_length = size_ff;
                        result.frame_last     = size_ff == 16'd0;
                     end
                  end
               end
               PH_PAY: begin
                  result.event_res      = EV_PAYLOAD;
                  result.msg_code       = type_ff;
                  result.payload_length = size_ff;
                  result.payload_value  = item.data_byte;
                  result.frame_last     = remain_dec == 16'd0;
               end
               default: begin
                  if (item.data_byte != INDICATOR_BYTE) begin
                     result.event_res  = EV_CLOSED_ERR;
                     result.error_code = ERR_BAD_IND;
                  end
               end
            endcase
            if (frame_end && close_req)
               result.event_res = EV_CLOSED_REQ;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IND;
         acc_ff    <= '0;
         cnt_ff    <= '0;
         size_ff   <= '0;
         type_ff   <= '0;
         remain_ff <= '0;
         idle_ff   <= '0;
         ping_ff   <= 1'b0;
         closed_ff <= 1'b0;
         over_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         size_ff   <= size_in;
         type_ff   <= type_in;
         remain_ff <= remain_in;
         idle_ff   <= idle_in;
         ping_ff   <= ping_in;
         closed_ff <= closed_in;
         over_ff   <= over_in;
      end
   end

   // a closed session stays closed until reset
   a_closed_sticky: assert property (@(posedge clock) disable iff (reset)
      closed_ff |=> closed_ff)
      else $error("session reopened without reset");

   // payload phase always has bytes left
   a_pay_remaining: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAY) |-> (remain_ff != 16'd0))
      else $error("payload phase with nothing remaining");

   // an open session never holds an over-long varint count
   a_varint_count: assert property (@(posedge clock) disable iff (reset)
      !closed_ff |-> (cnt_ff < 3'(MAX_VARINT_BYTES)))
      else $error("varint group count out of range");

   // a ping request leaves the ping flag set
   a_ping_flag: assert property (@(posedge clock) disable iff (reset)
      (item_fire && (result.event_res == EV_PING)) |=> ping_ff)
      else $error("ping requested without setting outstanding flag");

endmodule

// ----- sv/vfd_out_reg.sv -----
module vfd_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  vfd_pkg::rsp_item_type result,
   output logic                  space,
   vfd_rsp_if.source             rsp_if
);
   import vfd_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type word_ff;

   // register is free when empty or being taken this cycle
   assign space = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load)
         valid_in = 1'b1;
      else if (rsp_if.ready)
         valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load)
         word_ff <= result;
   end

   assign rsp_if.valid          = valid_ff;
   assign rsp_if.event_res      = word_ff.event_res;
   assign rsp_if.msg_code       = word_ff.msg_code;
   assign rsp_if.payload_length = word_ff.payload_length;
   assign rsp_if.payload_value  = word_ff.payload_value;
   assign rsp_if.frame_last     = word_ff.frame_last;
   assign rsp_if.error_code     = word_ff.error_code;

endmodule

// ----- sv/varint_frame_deframer_keepalive.sv -----
// A taken request word waits in the input register; its result word is loaded
// into the result register when that has space. Throughput: one word per cycle
// unless rsp_if stalls; parser and keepalive update in one pass between them.
// Every request word (byte or tick) yields exactly one result word.
// Reset (synchronous, active high) empties both registers, opens the session,
// returns the parser to awaiting the indicator and loads register defaults.
module varint_frame_deframer_keepalive (
   input  logic        clock,
   input  logic        reset,
   vfd_req_if.sink     req_if,
   vfd_rsp_if.source   rsp_if,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import vfd_pkg::*;

   cfg_type      cfg;
   logic         drain;
   logic         item_fire;
   req_item_type item;
   rsp_item_type result;

   vfd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   vfd_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .drain     (drain),
      .item_fire (item_fire),
      .item      (item)
   );

   vfd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .item_fire (item_fire),
      .item      (item),
      .result    (result)
   );

   vfd_out_reg u_out_reg (
      .clock  (clock),
      .reset  (reset),
      .load   (item_fire),
      .result (result),
      .space  (drain),
      .rsp_if (rsp_if)
   );

endmodule
